// ===== src/amg_pkg.sv =====
// Shared constants, types and arithmetic helpers of the affine matrix generator.
// Used by every module and by the channel interfaces' users.
`default_nettype none
package amg_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;
  localparam int XW           = 36;
  localparam int HW           = 32 - FRAC_BITS;
  localparam int RN           = HW + 9;
  localparam longint RK       = ((64'sd1 <<< RN) + 359) / 360;
  localparam int OFS          = int'((64'sd1 <<< (HW - 1)) % 360);
  localparam int RW           = FRAC_BITS + 9;
  localparam int MW           = FRAC_BITS + 7;
  localparam longint FULL     = 64'sd360 <<< FRAC_BITS;
  localparam longint HALF     = 64'sd180 <<< FRAC_BITS;
  localparam longint QUARTER  = 64'sd90 <<< FRAC_BITS;
  localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint DEG2RAD  = 64'sd18740330;

  localparam logic [2:0] FN_AXIS  = 3'd0;
  localparam logic [2:0] FN_ROT_X = 3'd1;
  localparam logic [2:0] FN_ROT_Y = 3'd2;
  localparam logic [2:0] FN_ROT_Z = 3'd3;
  localparam logic [2:0] FN_SCALE = 3'd4;
  localparam logic [2:0] FN_TRANS = 3'd5;

  localparam logic [31:0] ATAN [30] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } req_t;

  typedef struct packed {
    req_t               req;
    logic               flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cstate_t;

  typedef logic [15:0][31:0] mat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(66'(p >>> FRAC_BITS));
  endfunction

endpackage
`default_nettype wire

// ===== src/amg_if.sv =====
// Request and row channels of the affine matrix generator.
// Valid/ready handshake; no package dependency.
`default_nettype none
interface amg_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic signed [31:0] third_value;
  logic signed [31:0] angle_degrees;
  modport source(output valid, func, first_value, second_value, third_value, angle_degrees,
                 input ready);
  modport sink(input valid, func, first_value, second_value, third_value, angle_degrees,
               output ready);
endinterface

interface amg_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] col_zero;
  logic signed [31:0] col_one;
  logic signed [31:0] col_two;
  logic signed [31:0] col_three;
  logic               last_row;
  modport source(output valid, row_index, col_zero, col_one, col_two, col_three, last_row,
                 input ready);
  modport sink(input valid, row_index, col_zero, col_one, col_two, col_three, last_row,
               output ready);
endinterface
`default_nettype wire

// ===== src/amg_front.sv =====
// Angle front end: modulo-360 reduction, quadrant fold and degree-to-radian scaling.
// Depends on amg_pkg; feeds the first CORDIC cell.
`default_nettype none
module amg_front import amg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  input  wire logic         in_valid,
  input  wire req_t         in_req,
  input  wire logic [31:0]  in_deg,
  output logic              out_valid,
  output cstate_t           out_st
);

  localparam int PW = 2 * HW + 10;

  logic v1, v2, v3;
  req_t r1, r2, r3;
  logic [HW-1:0] u1, q1;
  logic [FRAC_BITS-1:0] lo1;
  logic [RW-1:0] red2;
  logic [MW-1:0] mag3;
  logic neg3, flip3;

  logic [HW-1:0] hi, u;
  logic [PW-1:0] qprod;
  logic [HW-1:0] rem;
  logic [9:0] hm;
  logic signed [RW+1:0] rs, rf;
  logic fl;
  logic [MW+24:0] zprod;
  logic signed [XW-1:0] zm;

  always_comb begin
    hi = in_deg[31:FRAC_BITS];
    u = {~hi[HW-1], hi[HW-2:0]};
    qprod = PW'(u) * PW'(RK);
  end

  always_comb begin
    rem = u1 - HW'(q1 * HW'(360));
    if (rem[8:0] >= 9'(OFS)) hm = 10'(rem[8:0]) - 10'(OFS);
    else hm = 10'(rem[8:0]) + 10'd360 - 10'(OFS);
  end

  always_comb begin
    rs = (RW+2)'(red2);
    if ((RW+2)'(red2) >= (RW+2)'(HALF)) rs = rs - (RW+2)'(FULL);
    rf = rs;
    fl = 1'b0;
    if (rs > (RW+2)'(QUARTER)) begin
      rf = rs - (RW+2)'(HALF);
      fl = 1'b1;
    end else if (rs < -(RW+2)'(QUARTER)) begin
      rf = rs + (RW+2)'(HALF);
      fl = 1'b1;
    end
  end

  always_comb begin
    zprod = (MW+25)'(mag3) * (MW+25)'(DEG2RAD);
    zm = XW'(zprod[FRAC_BITS +: 32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1 <= in_req;
      u1 <= u;
      q1 <= qprod[RN +: HW];
      lo1 <= in_deg[FRAC_BITS-1:0];
      r2 <= r1;
      red2 <= {hm[8:0], lo1};
      r3 <= r2;
      neg3 <= rf < 0;
      mag3 <= MW'(rf < 0 ? -rf : rf);
      flip3 <= fl;
      out_st.req <= r3;
      out_st.flip <= flip3;
      out_st.x <= XW'(GAIN);
      out_st.y <= '0;
      out_st.z <= neg3 ? -zm : zm;
    end
  end

endmodule
`default_nettype wire

// ===== src/amg_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on amg_pkg; chained by the top level.
`default_nettype none
module amg_cell import amg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic [4:0]  step,
  input  wire logic        in_valid,
  input  wire cstate_t     in_st,
  output logic             out_valid,
  output cstate_t          out_st
);

  logic signed [XW-1:0] dx, dy, at;
  cstate_t nxt;

  always_comb begin
    dx = in_st.y >>> step;
    dy = in_st.x >>> step;
    at = XW'(ATAN[step]);
    nxt = in_st;
    if (!in_st.z[XW-1]) begin
      nxt.x = in_st.x - dx;
      nxt.y = in_st.y + dy;
      nxt.z = in_st.z - at;
    end else begin
      nxt.x = in_st.x + dx;
      nxt.y = in_st.y - dy;
      nxt.z = in_st.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) out_st <= nxt;
  end

endmodule
`default_nettype wire

// ===== src/amg_matrix.sv =====
// Matrix back end: sine/cosine scaling, Rodrigues products and entry assembly.
// Depends on amg_pkg; takes the last CORDIC cell's output.
`default_nettype none
module amg_matrix import amg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     adv,
  input  wire logic     in_valid,
  input  wire cstate_t  in_st,
  output logic          out_valid,
  output mat_t          mat
);

  logic v0, v1;
  req_t r0, r1, r2;
  logic signed [31:0] c0, s0;
  logic signed [31:0] c1, s1, c1m;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, xs1, ys1, zs1;
  logic signed [31:0] c2, s2, xs, ys, zs, xxc, yyc, zzc, xyc, xzc, yzc;
  logic signed [XW-1:0] xf, yf;
  logic signed [65:0] e [16];

  always_comb begin
    xf = in_st.flip ? -in_st.x : in_st.x;
    yf = in_st.flip ? -in_st.y : in_st.y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0 <= in_st.req;
      c0 <= sat32(66'(xf >>> (ANG_BITS - FRAC_BITS)));
      s0 <= sat32(66'(yf >>> (ANG_BITS - FRAC_BITS)));
      r1 <= r0;
      c1 <= c0;
      s1 <= s0;
      c1m <= sat32(66'(ONE) - 66'(c0));
      xx <= qmul(r0.vx, r0.vx);
      yy <= qmul(r0.vy, r0.vy);
      zz <= qmul(r0.vz, r0.vz);
      xy <= qmul(r0.vx, r0.vy);
      xz <= qmul(r0.vx, r0.vz);
      yz <= qmul(r0.vy, r0.vz);
      xs1 <= qmul(r0.vx, s0);
      ys1 <= qmul(r0.vy, s0);
      zs1 <= qmul(r0.vz, s0);
      r2 <= r1;
      c2 <= c1;
      s2 <= s1;
      xs <= xs1;
      ys <= ys1;
      zs <= zs1;
      xxc <= qmul(xx, c1m);
      yyc <= qmul(yy, c1m);
      zzc <= qmul(zz, c1m);
      xyc <= qmul(xy, c1m);
      xzc <= qmul(xz, c1m);
      yzc <= qmul(yz, c1m);
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) e[k] = '0;
    e[0] = 66'(ONE);
    e[5] = 66'(ONE);
    e[10] = 66'(ONE);
    e[15] = 66'(ONE);
    case (r2.func)
      FN_AXIS: begin
        e[0] = 66'(c2) + 66'(xxc);
        e[1] = 66'(xyc) - 66'(zs);
        e[2] = 66'(xzc) + 66'(ys);
        e[4] = 66'(xyc) + 66'(zs);
        e[5] = 66'(c2) + 66'(yyc);
        e[6] = 66'(yzc) - 66'(xs);
        e[8] = 66'(xzc) - 66'(ys);
        e[9] = 66'(yzc) + 66'(xs);
        e[10] = 66'(c2) + 66'(zzc);
      end
      FN_ROT_X: begin
        e[5] = 66'(c2);
        e[6] = -66'(s2);
        e[9] = 66'(s2);
        e[10] = 66'(c2);
      end
      FN_ROT_Y: begin
        e[0] = 66'(c2);
        e[2] = 66'(s2);
        e[8] = -66'(s2);
        e[10] = 66'(c2);
      end
      FN_ROT_Z: begin
        e[0] = 66'(c2);
        e[1] = -66'(s2);
        e[4] = 66'(s2);
        e[5] = 66'(c2);
      end
      FN_SCALE: begin
        e[0] = 66'(r2.vx);
        e[5] = 66'(r2.vy);
        e[10] = 66'(r2.vz);
      end
      FN_TRANS: begin
        e[3] = 66'(r2.vx);
        e[7] = 66'(r2.vy);
        e[11] = 66'(r2.vz);
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 16; k++) mat[k] = sat32(e[k]);
  end

endmodule
`default_nettype wire

// ===== src/affine_matrix_generator.sv =====
// Affine matrix generator top level: front end, CORDIC cell chain, matrix back end,
// and a row output register. Depends on amg_pkg, amg_if, amg_front, amg_cell, amg_matrix.
// A request passes the front end, the CORDIC cell chain and the matrix back end before its first row is shown.
// New items are taken only as fast as the four rows of each matrix leave on the one output channel.
// The whole pipeline holds while a finished matrix still has rows to send.
// Reset (synchronous, rst high) clears all valid flags and the row counter.
`default_nettype none
module affine_matrix_generator import amg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  amg_req_if.sink    req,
  amg_row_if.source  rsp
);

  logic adv;
  logic fv;
  cstate_t fst;
  logic cv [CORDIC_STEPS+1];
  cstate_t cs [CORDIC_STEPS+1];
  logic mv;
  mat_t m;
  logic mat_valid;
  mat_t mat;
  logic [1:0] row;
  req_t rq;

  assign adv = !mat_valid || (rsp.ready && row == 2'd3);
  assign req.ready = adv;

  always_comb begin
    rq.func = req.func;
    rq.vx = req.first_value;
    rq.vy = req.second_value;
    rq.vz = req.third_value;
  end

  amg_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(req.valid), .in_req(rq), .in_deg(req.angle_degrees),
    .out_valid(fv), .out_st(fst)
  );

  assign cv[0] = fv;
  assign cs[0] = fst;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    amg_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv), .step(5'(i)),
      .in_valid(cv[i]), .in_st(cs[i]),
      .out_valid(cv[i+1]), .out_st(cs[i+1])
    );
  end

  amg_matrix u_matrix (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(cv[CORDIC_STEPS]), .in_st(cs[CORDIC_STEPS]),
    .out_valid(mv), .mat(m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
      row <= 2'd0;
    end else if (adv) begin
      mat_valid <= mv;
      row <= 2'd0;
    end else if (rsp.ready) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) mat <= m;
  end

  assign rsp.valid = mat_valid;
  assign rsp.row_index = row;
  assign rsp.col_zero = mat[{row, 2'd0}];
  assign rsp.col_one = mat[{row, 2'd1}];
  assign rsp.col_two = mat[{row, 2'd2}];
  assign rsp.col_three = mat[{row, 2'd3}];
  assign rsp.last_row = row == 2'd3;

endmodule
`default_nettype wire
